// ----- rtl/rmt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmt_pkg: shared types and constants of the range median trilateration block
// Holds the item structs of both channels, the register map and the result
// record that the position solver hands to the top level.
// ----------------------------------------------------------------------------
package rmt_pkg;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;
	localparam int COORD_W = 14;
	localparam int MED_OUT_W = 12;

	localparam logic [2:0] REG_OFFSET = 3'd0;
	localparam logic [2:0] REG_MIN = 3'd1;
	localparam logic [2:0] REG_MAX = 3'd2;
	localparam logic [2:0] REG_BX = 3'd3;
	localparam logic [2:0] REG_CX = 3'd4;
	localparam logic [2:0] REG_CY = 3'd5;

	localparam logic [1:0] ANCHOR_NONE = 2'd3;

	typedef struct packed {
		logic [1:0] anchor_sel;
		logic [15:0] raw_distance_cm;
		logic report_ok;
	} rmt_in_t;

	typedef struct packed {
		logic sample_taken;
		logic [MED_OUT_W-1:0] anchor_median_cm;
		logic signed [15:0] pos_x_cm;
		logic signed [15:0] pos_y_cm;
		logic pos_valid;
	} rmt_out_t;

	typedef struct packed {
		logic done;
		logic upd;
		logic signed [15:0] x;
		logic signed [15:0] y;
	} rmt_pos_t;

endpackage

// ----- rtl/rmt_median.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmt_median: window store and median selector
// Keeps the sample windows of all three anchors in one memory, writes a new
// sample, reads the window back one entry a cycle and finds the median by
// ranking one candidate a cycle.
// ----------------------------------------------------------------------------
module rmt_median import rmt_pkg::*; #(
	parameter int WINDOW_LEN = 5,
	parameter int DIST_BITS = 12
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic prime,
	input logic [1:0] anchor,
	input logic [$clog2(WINDOW_LEN)-1:0] slot,
	input logic [DIST_BITS-1:0] value,
	output logic done,
	output logic [DIST_BITS-1:0] median
);

	localparam int AW = $clog2(3 * WINDOW_LEN);
	localparam int IW = $clog2(WINDOW_LEN);
	localparam int CW = $clog2(WINDOW_LEN + 1);
	localparam int HALF = WINDOW_LEN / 2;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_FILL  = 5'b00010,
		S_WRITE = 5'b00100,
		S_READ  = 5'b01000,
		S_RANK  = 5'b10000
	} st_t;

	st_t st_q;
	logic [DIST_BITS-1:0] mem [3*WINDOW_LEN];
	logic [DIST_BITS-1:0] rd_q;
	logic rd_vld_q;
	logic [IW-1:0] rd_idx_q;
	logic [DIST_BITS-1:0] win_q [WINDOW_LEN];
	logic [AW-1:0] base_q;
	logic [IW-1:0] slot_q;
	logic [DIST_BITS-1:0] value_q;
	logic [CW-1:0] k_q;
	logic [IW-1:0] rank_q;
	logic done_q;
	logic [DIST_BITS-1:0] median_q;

	logic wr_en;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	logic [DIST_BITS-1:0] cand;
	logic [CW-1:0] lt_cnt;
	logic [CW-1:0] le_cnt;
	logic found;

	assign wr_en = (st_q == S_FILL) || (st_q == S_WRITE);
	assign wr_addr = (st_q == S_FILL) ? base_q + AW'(k_q) : base_q + AW'(slot_q);
	assign rd_addr = base_q + AW'(k_q);

	always_comb begin
		cand = win_q[rank_q];
		lt_cnt = '0;
		le_cnt = '0;
		for (int k = 0; k < WINDOW_LEN; k++) begin
			lt_cnt = lt_cnt + CW'(win_q[k] < cand);
			le_cnt = le_cnt + CW'(win_q[k] <= cand);
		end
		found = (lt_cnt <= CW'(HALF)) && (le_cnt > CW'(HALF));
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= value_q;
		end
		rd_q <= mem[rd_addr];
		if (rd_vld_q) begin
			win_q[rd_idx_q] <= rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			k_q <= '0;
			rank_q <= '0;
			rd_vld_q <= 1'b0;
			rd_idx_q <= '0;
			done_q <= 1'b0;
			base_q <= '0;
			slot_q <= '0;
			value_q <= '0;
			median_q <= '0;
		end else begin
			done_q <= 1'b0;
			rd_vld_q <= (st_q == S_READ) && (k_q < CW'(WINDOW_LEN));
			rd_idx_q <= k_q[IW-1:0];
			unique case (st_q)
				S_IDLE: begin
					if (start) begin
						base_q <= AW'(anchor) * AW'(WINDOW_LEN);
						slot_q <= slot;
						value_q <= value;
						k_q <= '0;
						st_q <= prime ? S_FILL : S_WRITE;
					end
				end
				S_FILL: begin
					if (k_q == CW'(WINDOW_LEN - 1)) begin
						median_q <= value_q;
						done_q <= 1'b1;
						st_q <= S_IDLE;
					end else begin
						k_q <= k_q + CW'(1);
					end
				end
				S_WRITE: begin
					k_q <= '0;
					st_q <= S_READ;
				end
				S_READ: begin
					if (k_q == CW'(WINDOW_LEN)) begin
						rank_q <= '0;
						st_q <= S_RANK;
					end else begin
						k_q <= k_q + CW'(1);
					end
				end
				S_RANK: begin
					if (found || rank_q == IW'(WINDOW_LEN - 1)) begin
						median_q <= cand;
						done_q <= 1'b1;
						st_q <= S_IDLE;
					end else begin
						rank_q <= rank_q + IW'(1);
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign median = median_q;

endmodule

// ----- rtl/rmt_solve.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmt_solve: serial trilateration solver
// Builds both numerators with a shift-and-add multiplier that takes one
// multiplier bit a cycle, and divides with a restoring divider that makes
// one quotient bit a cycle.
// ----------------------------------------------------------------------------
module rmt_solve import rmt_pkg::*; #(
	parameter int DIST_BITS = 12
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [DIST_BITS-1:0] r0,
	input logic [DIST_BITS-1:0] r1,
	input logic [DIST_BITS-1:0] r2,
	input logic [COORD_W-1:0] bx,
	input logic [COORD_W-1:0] cx,
	input logic [COORD_W-1:0] cy,
	output rmt_pos_t res
);

	localparam int SQ_W = (2 * DIST_BITS > 2 * COORD_W) ? 2 * DIST_BITS : 2 * COORD_W;
	localparam int ACC_W = SQ_W + 19;
	localparam int MS = (DIST_BITS > COORD_W + 1) ? DIST_BITS : COORD_W + 1;
	localparam int CW = $clog2(ACC_W + 1);
	localparam int RW = COORD_W + 2;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_MUL  = 4'b0010,
		S_ABS  = 4'b0100,
		S_DIV  = 4'b1000
	} st_t;

	typedef enum logic [3:0] {
		OP_R0X, OP_R1X, OP_BX, OP_DIVX, OP_R0Y, OP_R2Y, OP_CX, OP_CY, OP_XC, OP_DIVY
	} op_t;

	st_t st_q;
	op_t op_q;
	logic [CW-1:0] cnt_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [ACC_W-1:0] mc_q;
	logic [MS-1:0] mp_q;
	logic neg_q;
	logic [ACC_W-1:0] dq_q;
	logic [RW-1:0] rem_q;
	logic qneg_q;
	logic signed [ACC_W-1:0] x_q;
	rmt_pos_t res_q;

	op_t ld_op;
	logic [ACC_W-1:0] ld_mc;
	logic [MS-1:0] ld_mp;
	logic ld_neg;
	logic [ACC_W-1:0] x_mag;
	logic signed [ACC_W-1:0] acc_n;
	logic [COORD_W:0] dv;
	logic [RW-1:0] rs;
	logic ge;
	logic [ACC_W-1:0] dq_n;
	logic signed [ACC_W-1:0] quot;

	function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] v);
		logic signed [15:0] r;
		if (v > $signed(ACC_W'(32767))) begin
			r = 16'sh7fff;
		end else if (v < -$signed(ACC_W'(32768))) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	assign x_mag = x_q[ACC_W-1] ? ACC_W'(-x_q) : ACC_W'(x_q);

	always_comb begin
		if (st_q == S_IDLE) begin
			ld_op = OP_R0X;
		end else if (st_q == S_DIV) begin
			ld_op = OP_R0Y;
		end else begin
			ld_op = op_t'(op_q + 4'd1);
		end
		ld_mc = '0;
		ld_mp = '0;
		ld_neg = 1'b0;
		case (ld_op)
			OP_R0X, OP_R0Y: begin
				ld_mc = ACC_W'(r0);
				ld_mp = MS'(r0);
			end
			OP_R1X: begin
				ld_mc = ACC_W'(r1);
				ld_mp = MS'(r1);
				ld_neg = 1'b1;
			end
			OP_R2Y: begin
				ld_mc = ACC_W'(r2);
				ld_mp = MS'(r2);
				ld_neg = 1'b1;
			end
			OP_BX: begin
				ld_mc = ACC_W'(bx);
				ld_mp = MS'(bx);
			end
			OP_CX: begin
				ld_mc = ACC_W'(cx);
				ld_mp = MS'(cx);
			end
			OP_CY: begin
				ld_mc = ACC_W'(cy);
				ld_mp = MS'(cy);
			end
			OP_XC: begin
				// Subtracts 2*cx*x, so a positive x makes this term negative.
				ld_mc = x_mag;
				ld_mp = MS'({cx, 1'b0});
				ld_neg = ~x_q[ACC_W-1];
			end
			default: begin
				ld_mc = '0;
			end
		endcase
	end

	always_comb begin
		if (!mp_q[0]) begin
			acc_n = acc_q;
		end else if (neg_q) begin
			acc_n = acc_q - $signed(mc_q);
		end else begin
			acc_n = acc_q + $signed(mc_q);
		end
		dv = (op_q == OP_DIVX) ? {bx, 1'b0} : {cy, 1'b0};
		rs = {rem_q[RW-2:0], dq_q[ACC_W-1]};
		ge = rs >= RW'(dv);
		dq_n = {dq_q[ACC_W-2:0], ge};
		quot = qneg_q ? -$signed(dq_n) : $signed(dq_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			op_q <= OP_R0X;
			cnt_q <= '0;
			acc_q <= '0;
			mc_q <= '0;
			mp_q <= '0;
			neg_q <= 1'b0;
			dq_q <= '0;
			rem_q <= '0;
			qneg_q <= 1'b0;
			x_q <= '0;
			res_q <= '0;
		end else begin
			res_q.done <= 1'b0;
			unique case (st_q)
				S_IDLE: begin
					if (start) begin
						if (bx == '0 || cy == '0) begin
							res_q.done <= 1'b1;
							res_q.upd <= 1'b0;
						end else begin
							op_q <= ld_op;
							mc_q <= ld_mc;
							mp_q <= ld_mp;
							neg_q <= ld_neg;
							acc_q <= '0;
							cnt_q <= '0;
							st_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					acc_q <= acc_n;
					mc_q <= {mc_q[ACC_W-2:0], 1'b0};
					mp_q <= {1'b0, mp_q[MS-1:1]};
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(MS - 1)) begin
						cnt_q <= '0;
						if (op_q == OP_BX || op_q == OP_XC) begin
							op_q <= op_t'(op_q + 4'd1);
							st_q <= S_ABS;
						end else begin
							op_q <= ld_op;
							mc_q <= ld_mc;
							mp_q <= ld_mp;
							neg_q <= ld_neg;
						end
					end
				end
				S_ABS: begin
					dq_q <= acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
					qneg_q <= acc_q[ACC_W-1];
					rem_q <= '0;
					cnt_q <= '0;
					st_q <= S_DIV;
				end
				S_DIV: begin
					rem_q <= ge ? rs - RW'(dv) : rs;
					dq_q <= dq_n;
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(ACC_W - 1)) begin
						cnt_q <= '0;
						if (op_q == OP_DIVX) begin
							x_q <= quot;
							acc_q <= '0;
							op_q <= ld_op;
							mc_q <= ld_mc;
							mp_q <= ld_mp;
							neg_q <= ld_neg;
							st_q <= S_MUL;
						end else begin
							res_q.done <= 1'b1;
							res_q.upd <= 1'b1;
							res_q.x <= sat16(x_q);
							res_q.y <= sat16(quot);
							st_q <= S_IDLE;
						end
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign res = res_q;

endmodule

// ----- rtl/range_median_trilateration.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_median_trilateration: median filtered ranging and 2D position solver
// Gates ranging reports, keeps a median window per anchor and trilaterates.
// ----------------------------------------------------------------------------
// Each input item is one ranging report for anchor 0, 1 or 2. The signed
// offset is added to the raw distance and the sample is kept only when the
// report succeeded and the corrected value lies strictly between min_cm and
// max_cm. The first kept sample of an anchor fills its whole window; later
// ones replace the oldest entry. Every item yields exactly one result item
// carrying the gate flag, the anchor's current median and the latest
// position. Once all three anchors hold samples, every item recomputes the
// position with anchor A at the origin, B on the x axis and C at (cx, cy),
// dividing with truncation toward zero and saturating to 16 bits. The block
// works on one item at a time. A kept sample that primes the window is
// written to every entry and is its own median; otherwise the window is read
// back through the single read port of its memory and the median is found by
// ranking one candidate per cycle. The position solve takes one multiplier
// bit per cycle in eight products of M bits, M being the larger of
// DIST_BITS and 15, and one quotient bit per cycle in two divisions of
// A bits, A being the accumulator width max(2*DIST_BITS, 28) + 19. An item
// whose result cannot leave waits in the output register while the next
// item is already taken. The window memory needs no clearing pass, since an
// anchor's window is only read after it was filled. Registers sit on an APB
// port at byte addresses 0, 4, ..., 20.
// ----------------------------------------------------------------------------
module range_median_trilateration import rmt_pkg::*; #(
	parameter int WINDOW_LEN = 5,
	parameter int DIST_BITS = 12
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input rmt_in_t in_item,
	output logic out_valid,
	input logic out_stall,
	output rmt_out_t out_item,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [ADDR_W-1:0] paddr,
	input logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic pready
);

	localparam int SW = $clog2(WINDOW_LEN);
	localparam logic [17:0] LIM = 18'((1 << DIST_BITS) - 1);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_GATE  = 6'b000010,
		S_MED   = 6'b000100,
		S_POS   = 6'b001000,
		S_SOLVE = 6'b010000,
		S_OUT   = 6'b100000
	} st_t;

	st_t st_q;

	// Configuration registers.
	logic signed [10:0] offset_q;
	logic [11:0] min_q;
	logic [11:0] max_q;
	logic [COORD_W-1:0] bx_q;
	logic [COORD_W-1:0] cx_q;
	logic [COORD_W-1:0] cy_q;

	// Captured item and per-anchor state.
	rmt_in_t item_q;
	logic taken_q;
	logic [2:0] primed_q;
	logic [SW-1:0] wslot_q [3];
	logic [DIST_BITS-1:0] med_q [3];
	logic signed [15:0] pos_x_q;
	logic signed [15:0] pos_y_q;
	logic out_valid_q;
	rmt_out_t out_q;

	logic cfg_wr;
	logic signed [17:0] corr;
	logic gate_ok;
	logic [DIST_BITS-1:0] sample;
	logic med_start;
	logic med_done;
	logic [DIST_BITS-1:0] med_val;
	logic solve_start;
	rmt_pos_t pos_res;
	logic [1:0] sel;
	logic [DIST_BITS-1:0] med_sel;
	logic [DIST_BITS+MED_OUT_W-1:0] med_ext;
	logic out_load;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			min_q <= 12'd10;
			max_q <= 12'd3000;
			bx_q <= COORD_W'(1000);
			cx_q <= COORD_W'(500);
			cy_q <= COORD_W'(800);
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_OFFSET: offset_q <= pwdata[10:0];
				REG_MIN: min_q <= pwdata[11:0];
				REG_MAX: max_q <= pwdata[11:0];
				REG_BX: bx_q <= pwdata[COORD_W-1:0];
				REG_CX: cx_q <= pwdata[COORD_W-1:0];
				REG_CY: cy_q <= pwdata[COORD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_OFFSET: prdata = DATA_W'(offset_q);
			REG_MIN: prdata = DATA_W'(min_q);
			REG_MAX: prdata = DATA_W'(max_q);
			REG_BX: prdata = DATA_W'(bx_q);
			REG_CX: prdata = DATA_W'(cx_q);
			REG_CY: prdata = DATA_W'(cy_q);
			default: prdata = '0;
		endcase
	end

	// Range gate on the captured item. The corrected value is always positive
	// when it passes, so only the upper saturation can apply.
	assign sel = item_q.anchor_sel;
	assign corr = $signed({2'b00, item_q.raw_distance_cm}) + 18'(offset_q);
	assign gate_ok = item_q.report_ok && (sel != ANCHOR_NONE)
		&& (corr > $signed({6'b0, min_q})) && (corr < $signed({6'b0, max_q}));
	assign sample = (corr > $signed(LIM)) ? DIST_BITS'(LIM) : corr[DIST_BITS-1:0];

	assign med_start = (st_q == S_GATE) && gate_ok;
	assign solve_start = (st_q == S_POS) && (&primed_q);

	rmt_median #(
		.WINDOW_LEN(WINDOW_LEN),
		.DIST_BITS(DIST_BITS)
	) u_median (
		.clk(clk),
		.arst_n(arst_n),
		.start(med_start),
		.prime(~primed_q[sel]),
		.anchor(sel),
		.slot(wslot_q[sel]),
		.value(sample),
		.done(med_done),
		.median(med_val)
	);

	rmt_solve #(
		.DIST_BITS(DIST_BITS)
	) u_solve (
		.clk(clk),
		.arst_n(arst_n),
		.start(solve_start),
		.r0(med_q[0]),
		.r1(med_q[1]),
		.r2(med_q[2]),
		.bx(bx_q),
		.cx(cx_q),
		.cy(cy_q),
		.res(pos_res)
	);

	// Median shown in the result; the extension keeps the low twelve bits
	// whatever DIST_BITS is.
	always_comb begin
		case (sel)
			2'd0: med_sel = med_q[0];
			2'd1: med_sel = med_q[1];
			2'd2: med_sel = med_q[2];
			default: med_sel = '0;
		endcase
		med_ext = {{MED_OUT_W{1'b0}}, med_sel};
	end

	assign out_load = (st_q == S_OUT) && (!out_valid_q || !out_stall);
	assign in_stall = (st_q != S_IDLE);

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_q <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			taken_q <= 1'b0;
			primed_q <= '0;
			for (int a = 0; a < 3; a++) begin
				wslot_q[a] <= '0;
				med_q[a] <= '0;
			end
			pos_x_q <= '0;
			pos_y_q <= '0;
			out_valid_q <= 1'b0;
			out_q <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				S_IDLE: begin
					if (in_valid) begin
						st_q <= S_GATE;
					end
				end
				S_GATE: begin
					taken_q <= gate_ok;
					st_q <= gate_ok ? S_MED : S_POS;
				end
				S_MED: begin
					if (med_done) begin
						med_q[sel] <= med_val;
						primed_q[sel] <= 1'b1;
						if (!primed_q[sel] || wslot_q[sel] == SW'(WINDOW_LEN - 1)) begin
							wslot_q[sel] <= '0;
						end else begin
							wslot_q[sel] <= wslot_q[sel] + SW'(1);
						end
						st_q <= S_POS;
					end
				end
				S_POS: begin
					st_q <= (&primed_q) ? S_SOLVE : S_OUT;
				end
				S_SOLVE: begin
					if (pos_res.done) begin
						if (pos_res.upd) begin
							pos_x_q <= pos_res.x;
							pos_y_q <= pos_res.y;
						end
						st_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						out_q.sample_taken <= taken_q;
						out_q.anchor_median_cm <= med_ext[MED_OUT_W-1:0];
						out_q.pos_x_cm <= pos_x_q;
						out_q.pos_y_cm <= pos_y_q;
						out_q.pos_valid <= &primed_q;
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_q;

endmodule
